/* rtl/sed_pkg.sv */
// ----------------------------------------------------------------------------
// sed_pkg
// Types, character codes and helper functions for the escape decoder.
// ----------------------------------------------------------------------------
package sed_pkg;

    localparam int CP_W       = 21;
    localparam int UNIT_W     = 16;
    localparam int OUTQ_DEPTH = 4;

    localparam logic [UNIT_W-1:0] SUR_HI_MIN = 16'hD800;
    localparam logic [UNIT_W-1:0] SUR_HI_MAX = 16'hDBFF;
    localparam logic [UNIT_W-1:0] SUR_LO_MIN = 16'hDC00;
    localparam logic [UNIT_W-1:0] SUR_LO_MAX = 16'hDFFF;
    localparam logic [UNIT_W-1:0] OCT_MAX    = 16'h00FF;
    localparam logic [CP_W-1:0]   SUPP_BASE  = 21'h10000;

    localparam logic [CP_W-1:0] CH_QUOTE  = 21'h22;
    localparam logic [CP_W-1:0] CH_APOS   = 21'h27;
    localparam logic [CP_W-1:0] CH_SLASH  = 21'h2F;
    localparam logic [CP_W-1:0] CH_BSLASH = 21'h5C;
    localparam logic [CP_W-1:0] CH_B      = 21'h62;
    localparam logic [CP_W-1:0] CH_F      = 21'h66;
    localparam logic [CP_W-1:0] CH_N      = 21'h6E;
    localparam logic [CP_W-1:0] CH_R      = 21'h72;
    localparam logic [CP_W-1:0] CH_T      = 21'h74;
    localparam logic [CP_W-1:0] CH_U      = 21'h75;
    localparam logic [CP_W-1:0] CH_X      = 21'h78;
    localparam logic [CP_W-1:0] CC_BS     = 21'h08;
    localparam logic [CP_W-1:0] CC_FF     = 21'h0C;
    localparam logic [CP_W-1:0] CC_LF     = 21'h0A;
    localparam logic [CP_W-1:0] CC_CR     = 21'h0D;
    localparam logic [CP_W-1:0] CC_TAB    = 21'h09;

    typedef enum logic [4:0] {
        MODE_PLAIN = 5'b00001,
        MODE_ESC   = 5'b00010,
        MODE_HEXU  = 5'b00100,
        MODE_HEXX  = 5'b01000,
        MODE_OCT   = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [CP_W-1:0] char_in;
        logic            end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [CP_W-1:0] char_out;
        logic            has_char;
        logic            bad_escape;
        logic            last_result;
    } out_item_t;

    typedef struct packed {
        logic [1:0] count;
        out_item_t  slot0;
        out_item_t  slot1;
    } step_res_t;

    function automatic out_item_t mk_char(input logic [CP_W-1:0] ch);
        out_item_t r;
        r.char_out    = ch;
        r.has_char    = 1'b1;
        r.bad_escape  = 1'b0;
        r.last_result = 1'b0;
        return r;
    endfunction

    function automatic out_item_t mk_err();
        out_item_t r;
        r.char_out    = '0;
        r.has_char    = 1'b0;
        r.bad_escape  = 1'b1;
        r.last_result = 1'b0;
        return r;
    endfunction

    function automatic logic is_octal(input logic [CP_W-1:0] c);
        return (c inside {[21'h30:21'h37]});
    endfunction

    // Returns {valid, value}.
    function automatic logic [4:0] hex_digit(input logic [CP_W-1:0] c);
        logic [4:0] r;
        if (c inside {[21'h30:21'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if ((c inside {[21'h61:21'h66]}) || (c inside {[21'h41:21'h46]})) begin
            r = {1'b1, c[3:0] + 4'd9};
        end else begin
            r = '0;
        end
        return r;
    endfunction

endpackage

/* rtl/sed_decode.sv */
// ----------------------------------------------------------------------------
// sed_decode
// Escape state registers and the single-step decode of one code point.
// ----------------------------------------------------------------------------
module sed_decode
    import sed_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  in_item_t  item,
    input  logic      step_en,
    output step_res_t res
);

    mode_t             mode_reg, mode_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [UNIT_W-1:0] acc_reg, acc_next;
    logic [UNIT_W-1:0] held_reg, held_next;
    logic              fault_reg, fault_next;

    logic [CP_W-1:0]   c;
    logic [2:0]        cnt_inc;
    logic [UNIT_W-1:0] acc_oct;
    logic [UNIT_W-1:0] acc_hex;
    logic [4:0]        hv;
    logic              go_main;
    logic              pre_v, main_v, end_v;
    out_item_t         pre_r, main_r, end_r;
    logic [1:0]        n_res;
    out_item_t         slot0, slot1;

    assign c       = item.char_in;
    assign cnt_inc = cnt_reg + 3'd1;
    assign acc_oct = {acc_reg[12:0], c[2:0]};
    assign hv      = hex_digit(c);
    assign acc_hex = {acc_reg[11:0], hv[3:0]};

    always_comb begin
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        held_next  = held_reg;
        fault_next = fault_reg;
        go_main    = 1'b1;
        pre_v      = 1'b0;
        pre_r      = '0;
        main_v     = 1'b0;
        main_r     = '0;
        end_v      = 1'b0;
        end_r      = '0;

        if (!fault_reg) begin
            if (mode_reg == MODE_OCT) begin
                if (is_octal(c)) begin
                    go_main  = 1'b0;
                    acc_next = acc_oct;
                    cnt_next = cnt_inc;
                    if (cnt_inc >= 3'd3) begin
                        mode_next = MODE_PLAIN;
                        main_v    = 1'b1;
                        if (acc_oct > OCT_MAX) begin
                            fault_next = 1'b1;
                            main_r     = mk_err();
                        end else begin
                            main_r = mk_char({5'b0, acc_oct});
                        end
                    end
                end else begin
                    pre_v     = 1'b1;
                    pre_r     = mk_char({5'b0, acc_reg});
                    mode_next = MODE_PLAIN;
                end
            end

            if (go_main) begin
                case (mode_next)
                    MODE_ESC: begin
                        mode_next = MODE_PLAIN;
                        if ((held_reg != '0) && (c != CH_U)) begin
                            fault_next = 1'b1;
                            main_v     = 1'b1;
                            main_r     = mk_err();
                        end else begin
                            case (c)
                                CH_QUOTE, CH_BSLASH, CH_SLASH, CH_APOS: begin
                                    main_v = 1'b1;
                                    main_r = mk_char(c);
                                end
                                CH_B: begin
                                    main_v = 1'b1;
                                    main_r = mk_char(CC_BS);
                                end
                                CH_F: begin
                                    main_v = 1'b1;
                                    main_r = mk_char(CC_FF);
                                end
                                CH_N: begin
                                    main_v = 1'b1;
                                    main_r = mk_char(CC_LF);
                                end
                                CH_R: begin
                                    main_v = 1'b1;
                                    main_r = mk_char(CC_CR);
                                end
                                CH_T: begin
                                    main_v = 1'b1;
                                    main_r = mk_char(CC_TAB);
                                end
                                CH_U: begin
                                    mode_next = MODE_HEXU;
                                    cnt_next  = '0;
                                    acc_next  = '0;
                                end
                                CH_X: begin
                                    mode_next = MODE_HEXX;
                                    cnt_next  = '0;
                                    acc_next  = '0;
                                end
                                default: begin
                                    if (is_octal(c)) begin
                                        mode_next = MODE_OCT;
                                        cnt_next  = 3'd1;
                                        acc_next  = {13'b0, c[2:0]};
                                    end else begin
                                        fault_next = 1'b1;
                                        main_v     = 1'b1;
                                        main_r     = mk_err();
                                    end
                                end
                            endcase
                        end
                    end
                    MODE_HEXU, MODE_HEXX: begin
                        if (!hv[4]) begin
                            fault_next = 1'b1;
                            main_v     = 1'b1;
                            main_r     = mk_err();
                        end else begin
                            acc_next = acc_hex;
                            cnt_next = cnt_inc;
                            if ((mode_next == MODE_HEXU) && (cnt_inc >= 3'd4)) begin
                                mode_next = MODE_PLAIN;
                                if (!(acc_hex inside {[SUR_HI_MIN:SUR_LO_MAX]})) begin
                                    main_v = 1'b1;
                                    if (held_reg != '0) begin
                                        fault_next = 1'b1;
                                        main_r     = mk_err();
                                    end else begin
                                        main_r = mk_char({5'b0, acc_hex});
                                    end
                                end else if (held_reg == '0) begin
                                    if (acc_hex <= SUR_HI_MAX) begin
                                        held_next = acc_hex;
                                    end else begin
                                        fault_next = 1'b1;
                                        main_v     = 1'b1;
                                        main_r     = mk_err();
                                    end
                                end else if (acc_hex < SUR_LO_MIN) begin
                                    fault_next = 1'b1;
                                    main_v     = 1'b1;
                                    main_r     = mk_err();
                                end else begin
                                    main_v    = 1'b1;
                                    main_r    = mk_char(SUPP_BASE
                                                + {1'b0, held_reg[9:0], acc_hex[9:0]});
                                    held_next = '0;
                                end
                            end else if ((mode_next == MODE_HEXX) && (cnt_inc >= 3'd2)) begin
                                mode_next = MODE_PLAIN;
                                main_v    = 1'b1;
                                main_r    = mk_char({13'b0, acc_hex[7:0]});
                            end
                        end
                    end
                    default: begin
                        mode_next = MODE_PLAIN;
                        if (c == CH_BSLASH) begin
                            mode_next = MODE_ESC;
                        end else if (held_reg != '0) begin
                            fault_next = 1'b1;
                            main_v     = 1'b1;
                            main_r     = mk_err();
                        end else begin
                            main_v = 1'b1;
                            main_r = mk_char(c);
                        end
                    end
                endcase
            end
        end

        if (item.end_of_text) begin
            if (!fault_next) begin
                if (mode_next == MODE_OCT) begin
                    end_v = 1'b1;
                    end_r = mk_char({5'b0, acc_next});
                end else if ((mode_next != MODE_PLAIN) || (held_next != '0)) begin
                    end_v = 1'b1;
                    end_r = mk_err();
                end
            end
            mode_next  = MODE_PLAIN;
            cnt_next   = '0;
            acc_next   = '0;
            held_next  = '0;
            fault_next = 1'b0;
        end
    end

    always_comb begin
        n_res = 2'(pre_v) + 2'(main_v) + 2'(end_v);
        slot0 = pre_v ? pre_r : (main_v ? main_r : end_r);
        slot1 = (pre_v && main_v) ? main_r : end_r;
        if (item.end_of_text) begin
            if (n_res == 2'd0) begin
                n_res = 2'd1;
                slot0 = '0;
            end
            if (n_res == 2'd1) begin
                slot0.last_result = 1'b1;
            end else begin
                slot1.last_result = 1'b1;
            end
        end
        res.count = n_res;
        res.slot0 = slot0;
        res.slot1 = slot1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_PLAIN;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            held_reg  <= '0;
            fault_reg <= 1'b0;
        end else if (step_en) begin
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            held_reg  <= held_next;
            fault_reg <= fault_next;
        end
    end

endmodule

/* rtl/sed_outq.sv */
// ----------------------------------------------------------------------------
// sed_outq
// Result queue that takes up to two results per cycle and gives one.
// ----------------------------------------------------------------------------
module sed_outq
    import sed_pkg::*;
#(
    parameter int DEPTH = OUTQ_DEPTH
)
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_cnt,
    input  out_item_t  push0,
    input  out_item_t  push1,
    output logic       room,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    out_item_t       entries_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   wr1;
    logic            pop;

    function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign wr1     = next_ptr(wr_ptr_reg);
    assign m_valid = (count_reg != '0);
    assign m_item  = entries_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;
    assign room    = (count_reg <= CW'(DEPTH - 2));

    always_comb begin
        rd_ptr_next = pop ? next_ptr(rd_ptr_reg) : rd_ptr_reg;
        case (push_cnt)
            2'd1:    wr_ptr_next = wr1;
            2'd2:    wr_ptr_next = next_ptr(wr1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        count_next = count_reg + CW'(push_cnt) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            entries_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            entries_reg[wr1] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/string_escape_decoder_top.sv */
// ----------------------------------------------------------------------------
// string_escape_decoder_top
// Streaming backslash-escape decoder with UTF-16 surrogate pairing.
// ----------------------------------------------------------------------------
// The decoder accepts one code point per clock while s_ready is high and
// decodes it from an input register into a result queue of OUTQ_DEPTH_P
// entries once the queue has room. A result passes through the input
// register and the result queue before it is visible on the m_ channel.
// An item that ends an octal escape with a second character can give two
// results; the result channel drains one per cycle while m_ready is high,
// so many such items are held back by the single read port of the queue.
// The input register holds an item while fewer than two entries are free.
module string_escape_decoder_top
    import sed_pkg::*;
#(
    parameter int OUTQ_DEPTH_P = OUTQ_DEPTH
)
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    in_item_t  item_reg;
    logic      item_valid_reg, item_valid_next;
    logic      room;
    logic      process;
    step_res_t step;
    logic [1:0] push_cnt;

    assign process         = item_valid_reg && room;
    assign s_ready         = !item_valid_reg || room;
    assign item_valid_next = (s_valid && s_ready) || (item_valid_reg && !room);
    assign push_cnt        = process ? step.count : 2'd0;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else begin
            item_valid_reg <= item_valid_next;
        end
    end

    sed_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (item_reg),
        .step_en (process),
        .res     (step)
    );

    sed_outq #(
        .DEPTH (OUTQ_DEPTH_P)
    ) u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cnt (push_cnt),
        .push0    (step.slot0),
        .push1    (step.slot1),
        .room     (room),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_data)
    );

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> item_valid_reg)
        else $error("Accepted transaction did not reach the input register.");

    a_end_marks_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (process && item_reg.end_of_text) |->
            ((step.count == 2'd1 && step.slot0.last_result) ||
             (step.count == 2'd2 && step.slot1.last_result && !step.slot0.last_result)))
        else $error("End of text did not give exactly one final result.");

    a_no_early_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (process && !item_reg.end_of_text) |->
            (!step.slot0.last_result && !step.slot1.last_result && step.count != 2'd3))
        else $error("Result marked last before end of text.");

endmodule

/* tb/string_escape_decoder_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_escape_decoder_top_tb
// Self-checking testbench for the streaming escape decoder. Directed strings
// cover the code point extremes, octal termination and overflow, surrogate
// faults and truncated escapes. Random strings of well-formed escapes with
// occasional malformed ones follow. Every accepted transaction is decoded by
// a behavioral decoder in the testbench, and each result is checked in order.
// ----------------------------------------------------------------------------
module string_escape_decoder_top_tb
    import sed_pkg::*;
();

    typedef logic [CP_W-1:0] cp_q_t[$];

    localparam logic [CP_W-1:0] CH_ZERO     = 21'h30;
    localparam logic [CP_W-1:0] CH_FOUR     = 21'h34;
    localparam logic [CP_W-1:0] CH_SEVEN    = 21'h37;
    localparam logic [CP_W-1:0] CH_EIGHT    = 21'h38;
    localparam logic [CP_W-1:0] CH_NINE     = 21'h39;
    localparam logic [CP_W-1:0] CH_UPPER_A  = 21'h41;
    localparam logic [CP_W-1:0] CH_UPPER_D  = 21'h44;
    localparam logic [CP_W-1:0] CH_UPPER_F  = 21'h46;
    localparam logic [CP_W-1:0] CH_LOWER_A  = 21'h61;
    localparam logic [CP_W-1:0] CH_LOWER_C  = 21'h63;
    localparam logic [CP_W-1:0] CH_LOWER_D  = 21'h64;
    localparam logic [CP_W-1:0] CH_LOWER_F  = 21'h66;
    localparam logic [CP_W-1:0] CH_LOWER_G  = 21'h67;
    localparam logic [CP_W-1:0] CH_LOWER_Q  = 21'h71;
    localparam logic [CP_W-1:0] CH_LOWER_Z  = 21'h7A;
    localparam logic [CP_W-1:0] CP_ALL_ONES = 21'h1FFFFF;

    localparam int RANDOM_ITEMS = 1350;
    localparam int QUIET_TAIL   = 250;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    mode_t       dec_mode;
    logic [2:0]  dec_count;
    logic [15:0] dec_acc;
    logic [15:0] held_hi;
    logic        dec_fault;
    out_item_t   step_out[$];
    out_item_t   expected_chars[$];

    int  err_count   = 0;
    int  items_sent  = 0;
    int  results_seen = 0;
    bit  idle_on     = 1'b1;

    string_escape_decoder_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Behavioral decoder
    // ------------------------------------------------------------------
    function automatic void clear_decoder();
        dec_mode  = MODE_PLAIN;
        dec_count = '0;
        dec_acc   = '0;
        held_hi   = '0;
        dec_fault = 1'b0;
    endfunction

    function automatic void emit(input logic [CP_W-1:0] ch, input logic has,
                                 input logic bad);
        out_item_t r;
        r.char_out    = ch;
        r.has_char    = has;
        r.bad_escape  = bad;
        r.last_result = 1'b0;
        step_out.insert(step_out.size(), r);
    endfunction

    function automatic void flag_fault();
        if (!dec_fault) begin
            dec_fault = 1'b1;
            emit('0, 1'b0, 1'b1);
        end
    endfunction

    function automatic bit is_oct(input logic [CP_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_SEVEN);
    endfunction

    function automatic int hex_nibble(input logic [CP_W-1:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
        if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
        return -1;
    endfunction

    function automatic void take_unit(input logic [15:0] u);
        logic [CP_W-1:0] hi_off;
        logic [CP_W-1:0] lo_off;
        if (u < SUR_HI_MIN || u > SUR_LO_MAX) begin
            if (held_hi != '0) flag_fault();
            else emit(CP_W'(u), 1'b1, 1'b0);
            return;
        end
        if (held_hi == '0) begin
            if (u <= SUR_HI_MAX) held_hi = u;
            else flag_fault();
            return;
        end
        if (u < SUR_LO_MIN) begin
            flag_fault();
            return;
        end
        hi_off = CP_W'(held_hi - SUR_HI_MIN);
        lo_off = CP_W'(u - SUR_LO_MIN);
        emit(SUPP_BASE + (hi_off << 10) + lo_off, 1'b1, 1'b0);
        held_hi = '0;
    endfunction

    function automatic void feed_char(input logic [CP_W-1:0] c);
        int v;
        if (dec_mode == MODE_OCT) begin
            if (is_oct(c)) begin
                dec_acc = 16'(dec_acc * 8 + (c - CH_ZERO));
                dec_count = dec_count + 3'd1;
                if (dec_count >= 3) begin
                    dec_mode = MODE_PLAIN;
                    if (dec_acc > OCT_MAX) flag_fault();
                    else emit(CP_W'(dec_acc), 1'b1, 1'b0);
                end
                return;
            end
            emit(CP_W'(dec_acc), 1'b1, 1'b0);
            dec_mode = MODE_PLAIN;
        end
        case (dec_mode)
            MODE_ESC: begin
                dec_mode = MODE_PLAIN;
                if (held_hi != '0 && c != CH_U) begin
                    flag_fault();
                    return;
                end
                case (c)
                    CH_QUOTE, CH_BSLASH, CH_SLASH, CH_APOS: emit(c, 1'b1, 1'b0);
                    CH_B: emit(CC_BS, 1'b1, 1'b0);
                    CH_F: emit(CC_FF, 1'b1, 1'b0);
                    CH_N: emit(CC_LF, 1'b1, 1'b0);
                    CH_R: emit(CC_CR, 1'b1, 1'b0);
                    CH_T: emit(CC_TAB, 1'b1, 1'b0);
                    CH_U, CH_X: begin
                        dec_mode  = (c == CH_U) ? MODE_HEXU : MODE_HEXX;
                        dec_count = '0;
                        dec_acc   = '0;
                    end
                    default: begin
                        if (is_oct(c)) begin
                            dec_mode  = MODE_OCT;
                            dec_count = 3'd1;
                            dec_acc   = 16'(c - CH_ZERO);
                        end else begin
                            flag_fault();
                        end
                    end
                endcase
            end
            MODE_HEXU, MODE_HEXX: begin
                v = hex_nibble(c);
                if (v < 0) begin
                    flag_fault();
                    return;
                end
                dec_acc   = {dec_acc[11:0], 4'(v)};
                dec_count = dec_count + 3'd1;
                if (dec_mode == MODE_HEXU && dec_count >= 4) begin
                    dec_mode = MODE_PLAIN;
                    take_unit(dec_acc);
                end else if (dec_mode == MODE_HEXX && dec_count >= 2) begin
                    dec_mode = MODE_PLAIN;
                    emit(CP_W'(dec_acc[7:0]), 1'b1, 1'b0);
                end
            end
            default: begin
                dec_mode = MODE_PLAIN;
                if (c == CH_BSLASH) dec_mode = MODE_ESC;
                else if (held_hi != '0) flag_fault();
                else emit(c, 1'b1, 1'b0);
            end
        endcase
    endfunction

    function automatic void decode_transaction(input in_item_t it);
        step_out.delete();
        if (!dec_fault) feed_char(it.char_in);
        if (it.end_of_text) begin
            if (!dec_fault) begin
                if (dec_mode == MODE_OCT) begin
                    dec_mode = MODE_PLAIN;
                    emit(CP_W'(dec_acc), 1'b1, 1'b0);
                end else if (dec_mode != MODE_PLAIN || held_hi != '0) begin
                    flag_fault();
                end
            end
            if (step_out.size() == 0) emit('0, 1'b0, 1'b0);
            step_out[step_out.size()-1].last_result = 1'b1;
            clear_decoder();
        end
        foreach (step_out[i]) expected_chars.insert(expected_chars.size(), step_out[i]);
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= 40) $display("ERROR: %s", msg);
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no transaction pending",
                                          results_seen));
            end else begin
                want = expected_chars.pop_front();
                if (m_data.char_out !== want.char_out)
                    report_mismatch($sformatf("result %0d char_out %h, expected %h",
                                              results_seen, m_data.char_out, want.char_out));
                if (m_data.has_char !== want.has_char)
                    report_mismatch($sformatf("result %0d has_char %b, expected %b",
                                              results_seen, m_data.has_char, want.has_char));
                if (m_data.bad_escape !== want.bad_escape)
                    report_mismatch($sformatf("result %0d bad_escape %b, expected %b",
                                              results_seen, m_data.bad_escape,
                                              want.bad_escape));
                if (m_data.last_result !== want.last_result)
                    report_mismatch($sformatf("result %0d last_result %b, expected %b",
                                              results_seen, m_data.last_result,
                                              want.last_result));
            end
            results_seen++;
        end
    end

    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic send_item(input in_item_t it);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        decode_transaction(it);
        items_sent++;
    endtask

    task automatic send_text(input cp_q_t text);
        in_item_t it;
        foreach (text[i]) begin
            it.char_in     = text[i];
            it.end_of_text = (i == text.size() - 1);
            send_item(it);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_chars.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [CP_W-1:0] hex_char(input logic [3:0] v);
        if (v < 10) return CH_ZERO + CP_W'(v);
        return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + CP_W'(v - 4'd10);
    endfunction

    function automatic void add_hex(ref cp_q_t s, input logic [15:0] v, input int digits);
        for (int i = digits - 1; i >= 0; i--) s.insert(s.size(), hex_char(v[i*4 +: 4]));
    endfunction

    function automatic logic [CP_W-1:0] escape_letter();
        case ($urandom_range(0, 8))
            0: return CH_QUOTE;
            1: return CH_BSLASH;
            2: return CH_SLASH;
            3: return CH_APOS;
            4: return CH_B;
            5: return CH_F;
            6: return CH_N;
            7: return CH_R;
            default: return CH_T;
        endcase
    endfunction

    function automatic void add_token(ref cp_q_t s, input bit noisy);
        logic [CP_W-1:0] c;
        logic [15:0]     v;
        int              n;
        if (!noisy) begin
            case ($urandom_range(0, 7))
                0, 1: begin
                    c = CP_W'($urandom_range(32, 126));
                    s.insert(s.size(), c == CH_BSLASH ? CH_LOWER_Q : c);
                end
                2: begin
                    c = ($urandom_range(0, 3) == 0)
                        ? CP_W'($urandom_range(SUR_HI_MIN, SUR_LO_MAX))
                        : CP_W'($urandom_range(0, CP_ALL_ONES));
                    s.insert(s.size(), c == CH_BSLASH ? CH_LOWER_Q : c);
                end
                3: begin
                    s.insert(s.size(), CH_BSLASH);
                    s.insert(s.size(), escape_letter());
                end
                4: begin
                    s.insert(s.size(), CH_BSLASH);
                    s.insert(s.size(), CH_X);
                    add_hex(s, 16'($urandom_range(0, 255)), 2);
                end
                5: begin
                    v = 16'($urandom_range(0, 16'hFFFF));
                    if (v >= SUR_HI_MIN && v <= SUR_LO_MAX) v = v ^ 16'h8000;
                    s.insert(s.size(), CH_BSLASH);
                    s.insert(s.size(), CH_U);
                    add_hex(s, v, 4);
                end
                6: begin
                    s.insert(s.size(), CH_BSLASH);
                    s.insert(s.size(), CH_U);
                    add_hex(s, SUR_HI_MIN + 16'($urandom_range(0, 16'h3FF)), 4);
                    s.insert(s.size(), CH_BSLASH);
                    s.insert(s.size(), CH_U);
                    add_hex(s, SUR_LO_MIN + 16'($urandom_range(0, 16'h3FF)), 4);
                end
                default: begin
                    n = $urandom_range(1, 3);
                    s.insert(s.size(), CH_BSLASH);
                    s.insert(s.size(), CH_ZERO + CP_W'((n == 3) ? $urandom_range(0, 3)
                                                                : $urandom_range(0, 7)));
                    for (int i = 1; i < n; i++)
                        s.insert(s.size(), CH_ZERO + CP_W'($urandom_range(0, 7)));
                end
            endcase
        end else begin
            s.insert(s.size(), CH_BSLASH);
            case ($urandom_range(0, 5))
                0: begin
                    case ($urandom_range(0, 3))
                        0: s.insert(s.size(), CH_EIGHT);
                        1: s.insert(s.size(), CH_NINE);
                        2: s.insert(s.size(), CH_LOWER_Z);
                        default: s.insert(s.size(), CP_ALL_ONES);
                    endcase
                end
                1: begin
                    s.insert(s.size(), CH_X);
                    if ($urandom_range(0, 1))
                        s.insert(s.size(), hex_char(4'($urandom_range(0, 15))));
                    s.insert(s.size(), CH_LOWER_G);
                end
                2: begin
                    s.insert(s.size(), CH_U);
                    add_hex(s, SUR_LO_MIN + 16'($urandom_range(0, 16'h3FF)), 4);
                end
                3: begin
                    s.insert(s.size(), CH_U);
                    add_hex(s, SUR_HI_MIN + 16'($urandom_range(0, 16'h3FF)), 4);
                end
                4: begin
                    s.insert(s.size(), CH_FOUR + CP_W'($urandom_range(0, 3)));
                    s.insert(s.size(), CH_ZERO + CP_W'($urandom_range(0, 7)));
                    s.insert(s.size(), CH_ZERO + CP_W'($urandom_range(0, 7)));
                end
                default: begin
                    s.insert(s.size(), CH_U);
                    add_hex(s, 16'($urandom_range(0, 255)), 2);
                end
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_plain_extremes();
        send_text('{21'h0, CP_ALL_ONES, CP_W'(SUR_HI_MIN)});
    endtask

    task automatic test_octal_termination();
        send_text('{CH_BSLASH, CH_SEVEN, CH_LOWER_Q, CH_BSLASH, CH_FOUR});
    endtask

    task automatic test_octal_overflow();
        send_text('{CH_BSLASH, CH_FOUR, CH_ZERO, CH_ZERO});
    endtask

    task automatic test_lone_low_surrogate();
        send_text('{CH_BSLASH, CH_U, CH_LOWER_D, CH_LOWER_C, CH_ZERO, CH_ZERO,
                    CH_LOWER_Q});
    endtask

    task automatic test_truncated_escapes();
        send_text('{CH_BSLASH});
        send_text('{CH_BSLASH, CH_NINE, CH_LOWER_Q});
        send_text('{CH_BSLASH, CH_U, CH_UPPER_D, CH_EIGHT, CH_ZERO, CH_ZERO});
    endtask

    task automatic test_random_strings(input int target);
        cp_q_t text;
        int    ntok;
        while (items_sent < target) begin
            text.delete();
            ntok = $urandom_range(1, 10);
            for (int i = 0; i < ntok; i++) add_token(text, $urandom_range(0, 19) == 0);
            if (items_sent > target - QUIET_TAIL) idle_on = 1'b0;
            send_text(text);
            if ($urandom_range(0, 39) == 0) wait_drained();
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        clear_decoder();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_plain_extremes();
        test_octal_termination();
        test_octal_overflow();
        test_lone_low_surrogate();
        test_truncated_escapes();
        wait_drained();
        test_random_strings(items_sent + RANDOM_ITEMS);

        s_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/sed_pkg.sv
rtl/sed_decode.sv
rtl/sed_outq.sv
rtl/string_escape_decoder_top.sv
tb/string_escape_decoder_top_tb.sv
